// ----- hw/rtl/oiu_pkg.sv -----
// Shared widths, opcode constants and the execute result type of the operate unit.
package oiu_pkg;

    localparam int DATA_W    = 16;
    localparam int ACC_COUNT = 8;
    localparam int ACC_IDX_W = $clog2(ACC_COUNT);
    localparam int INSTR_W   = 16;

    // group 1 rotate and swap selects, instruction bits 3:1
    localparam logic [2:0] ROT_NONE  = 3'd0;
    localparam logic [2:0] ROT_BSW6  = 3'd1;
    localparam logic [2:0] ROT_RAL   = 3'd2;
    localparam logic [2:0] ROT_RTL   = 3'd3;
    localparam logic [2:0] ROT_RAR   = 3'd4;
    localparam logic [2:0] ROT_RTR   = 3'd5;
    localparam logic [2:0] ROT_NONE2 = 3'd6;
    localparam logic [2:0] ROT_BSW8  = 3'd7;

    // register-op codes, instruction bits 7:4
    localparam logic [3:0] ROP_MOV = 4'd0;
    localparam logic [3:0] ROP_SWP = 4'd1;
    localparam logic [3:0] ROP_OR  = 4'd2;
    localparam logic [3:0] ROP_XOR = 4'd3;
    localparam logic [3:0] ROP_SHL = 4'd4;
    localparam logic [3:0] ROP_SLI = 4'd5;
    localparam logic [3:0] ROP_SHR = 4'd6;
    localparam logic [3:0] ROP_SRI = 4'd7;
    localparam logic [3:0] ROP_ASR = 4'd8;
    localparam logic [3:0] ROP_ASI = 4'd9;

    typedef struct packed {
        logic              skip;
        logic              halt;
        logic [DATA_W-1:0] dest_value;
        logic              link;
        logic              src_we;
        logic [DATA_W-1:0] src_value;
    } exec_result_t;

endpackage

// ----- hw/rtl/operate_instruction_unit.sv -----
// Top level of the operate instruction unit: word registers, execute stage, state.
//
// Each accepted instruction word is held in an input register, executed against
// the accumulator file and link, and its result word is held in an output
// register. One word is accepted per clock while the output is not stalled;
// m_valid rises once the word has passed the input and output registers. The
// accumulator and link update in the execute cycle, so a following word always
// sees the effect of the one before it. The switch register is written through
// cfg_wr_en/cfg_wr_data with no wait.
module operate_instruction_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [oiu_pkg::DATA_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [oiu_pkg::INSTR_W-1:0] s_instruction,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_skip_next,
    output logic                        m_halt_request,
    output logic [oiu_pkg::DATA_W-1:0]  m_dest_value,
    output logic                        m_link_value
);
    import oiu_pkg::*;

    logic [DATA_W-1:0]  switch_reg;
    logic               in_valid_reg;
    logic [INSTR_W-1:0] instr_reg;
    logic               out_valid_reg;
    logic               skip_reg;
    logic               halt_reg;
    logic [DATA_W-1:0]  dest_reg;
    logic               link_reg;

    logic               exec_fire;
    logic [DATA_W-1:0]  dest_rdata;
    logic [DATA_W-1:0]  src_rdata;
    logic               link_rdata;
    exec_result_t       res;

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;

    oiu_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dest_idx   (instr_reg[12:10]),
        .src_idx    (instr_reg[2:0]),
        .dest_rdata (dest_rdata),
        .src_rdata  (src_rdata),
        .link_rdata (link_rdata),
        .wr_en      (exec_fire),
        .wr_res     (res)
    );

    oiu_exec u_exec (
        .instr      (instr_reg),
        .dest_val   (dest_rdata),
        .src_val    (src_rdata),
        .link_in    (link_rdata),
        .switch_val (switch_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_reg    <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                switch_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            instr_reg <= s_instruction;
        end
        if (exec_fire) begin
            skip_reg <= res.skip;
            halt_reg <= res.halt;
            dest_reg <= res.dest_value;
            link_reg <= res.link;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_skip_next    = skip_reg;
    assign m_halt_request = halt_reg;
    assign m_dest_value   = dest_reg;
    assign m_link_value   = link_reg;

endmodule

// ----- hw/rtl/oiu_state.sv -----
// Accumulator file with two read and two write ports, plus the link bit.
module oiu_state (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [oiu_pkg::ACC_IDX_W-1:0] dest_idx,
    input  logic [oiu_pkg::ACC_IDX_W-1:0] src_idx,
    output logic [oiu_pkg::DATA_W-1:0]    dest_rdata,
    output logic [oiu_pkg::DATA_W-1:0]    src_rdata,
    output logic                          link_rdata,
    input  logic                          wr_en,
    input  oiu_pkg::exec_result_t         wr_res
);
    import oiu_pkg::*;

    logic [DATA_W-1:0] acc_reg [ACC_COUNT];
    logic              link_reg;

    assign dest_rdata = acc_reg[dest_idx];
    assign src_rdata  = acc_reg[src_idx];
    assign link_rdata = link_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ACC_COUNT; i++) begin
                acc_reg[i] <= '0;
            end
            link_reg <= 1'b0;
        end else if (wr_en) begin
            // destination write wins when both ports hit the same entry
            for (int i = 0; i < ACC_COUNT; i++) begin
                if (i[ACC_IDX_W-1:0] == dest_idx) begin
                    acc_reg[i] <= wr_res.dest_value;
                end else if (wr_res.src_we && i[ACC_IDX_W-1:0] == src_idx) begin
                    acc_reg[i] <= wr_res.src_value;
                end
            end
            link_reg <= wr_res.link;
        end
    end

endmodule

// ----- hw/rtl/oiu_exec.sv -----
// Combinational execute logic for group 1, group 2 and register operate words.
module oiu_exec (
    input  logic [oiu_pkg::INSTR_W-1:0] instr,
    input  logic [oiu_pkg::DATA_W-1:0]  dest_val,
    input  logic [oiu_pkg::DATA_W-1:0]  src_val,
    input  logic                        link_in,
    input  logic [oiu_pkg::DATA_W-1:0]  switch_val,
    output oiu_pkg::exec_result_t       res
);
    import oiu_pkg::*;

    logic [DATA_W-1:0]   v;
    logic                l;
    logic [DATA_W:0]     ring;
    logic                test_hit;
    logic [3:0]          code;
    logic [3:0]          imm;
    logic [3:0]          cnt;
    logic [4:0]          lamt;
    logic [4:0]          ramt;
    logic [2*DATA_W-1:0] lw;
    logic [2*DATA_W:0]   rw;
    logic                fill;
    logic                arith;

    always_comb begin
        v        = dest_val;
        l        = link_in;
        ring     = {link_in, dest_val};
        code     = instr[7:4];
        imm      = instr[3:0];
        cnt      = src_val[3:0];
        res      = '0;
        test_hit = (instr[6] && v[DATA_W-1]) || (instr[5] && v == '0) || (instr[4] && l);
        lamt     = (code == ROP_SLI) ? ({1'b0, imm} + 5'd1) : {1'b0, cnt};
        ramt     = (code == ROP_SRI || code == ROP_ASI) ? ({1'b0, imm} + 5'd1)
                                                        : {1'b0, cnt};
        arith    = (code == ROP_ASR || code == ROP_ASI);
        fill     = arith && v[DATA_W-1];
        lw       = {{DATA_W{1'b0}}, v} << lamt;
        rw       = {{DATA_W{fill}}, v, 1'b0} >> ramt;

        if (!instr[8]) begin
            if (instr[7]) v = '0;
            if (instr[6]) l = 1'b0;
            if (instr[5]) v = ~v;
            if (instr[4]) l = ~l;
            if (instr[0]) begin
                if (v == '1) l = ~l;
                v = v + DATA_W'(1);
            end
            // rotate through the link as one 17-bit ring
            ring = {l, v};
            case (instr[3:1])
                ROT_BSW6: ring[DATA_W-1:0] = {v[15:12], v[5:0], v[11:6]};
                ROT_RAL:  ring = {ring[DATA_W-1:0], ring[DATA_W]};
                ROT_RTL:  ring = {ring[DATA_W-2:0], ring[DATA_W:DATA_W-1]};
                ROT_RAR:  ring = {ring[0], ring[DATA_W:1]};
                ROT_RTR:  ring = {ring[1:0], ring[DATA_W:2]};
                ROT_BSW8: ring[DATA_W-1:0] = {v[7:0], v[15:8]};
                default: ;
            endcase
            {l, v} = ring;
        end else if (instr[9]) begin
            case (code)
                ROP_MOV: v = src_val;
                ROP_SWP: begin
                    res.src_we    = 1'b1;
                    res.src_value = dest_val;
                    v = src_val;
                end
                ROP_OR:  v = dest_val | src_val;
                ROP_XOR: v = dest_val ^ src_val;
                ROP_SHL, ROP_SLI: begin
                    l = lw[DATA_W];
                    v = lw[DATA_W-1:0];
                end
                ROP_SHR, ROP_ASR: begin
                    if (cnt != 4'd0) begin
                        l = rw[0];
                        v = rw[DATA_W:1];
                    end
                end
                ROP_SRI, ROP_ASI: begin
                    l = rw[0];
                    v = rw[DATA_W:1];
                end
                default: ;
            endcase
        end else begin
            if (instr[0]) begin
                res.skip = 1'b0;
            end else if (!instr[3]) begin
                res.skip = test_hit;
            end else begin
                res.skip = !test_hit;
            end
            if (instr[7]) v = '0;
            if (instr[2]) v = v | switch_val;
            res.halt = instr[1];
        end
        res.dest_value = v;
        res.link       = l;
    end

endmodule

// ----- verif/oiu_result_checker.sv -----
// Result checker for the operate instruction unit: predicts each result word and compares it.
module oiu_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [oiu_pkg::DATA_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [oiu_pkg::INSTR_W-1:0] s_instruction,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_skip_next,
    input  logic                        m_halt_request,
    input  logic [oiu_pkg::DATA_W-1:0]  m_dest_value,
    input  logic                        m_link_value,
    output int                          fail_count,
    output int                          pending_count
);
    import oiu_pkg::*;

    typedef struct packed {
        logic              skip;
        logic              halt;
        logic [DATA_W-1:0] dest;
        logic              link;
    } op_word_t;

    logic [DATA_W-1:0] acc_file [ACC_COUNT];
    logic              link_reg;
    logic [DATA_W-1:0] switch_word;
    op_word_t          expected_q [$];
    op_word_t          got;
    op_word_t          want;
    int                mismatch_count = 0;

    function automatic op_word_t execute_word(input logic [INSTR_W-1:0] ins);
        logic [ACC_IDX_W-1:0] da;
        logic [ACC_IDX_W-1:0] sa;
        logic [7:0]           f;
        logic [DATA_W-1:0]    v;
        logic [DATA_W-1:0]    sv;
        logic [DATA_W:0]      ring;
        logic [31:0]          wide;
        logic                 hit;
        int                   cnt;
        op_word_t             r;
        da = ins[12:10];
        sa = ins[2:0];
        f  = ins[7:0];
        v  = acc_file[da];
        sv = acc_file[sa];
        r  = '0;
        if (!ins[8]) begin
            if (f[7]) v = '0;
            if (f[6]) link_reg = 1'b0;
            if (f[5]) v = ~v;
            if (f[4]) link_reg = ~link_reg;
            if (f[0]) begin
                if (v == 16'hFFFF) link_reg = ~link_reg;
                v = v + 1'b1;
            end
            ring = {link_reg, v};
            case (f[3:1])
                ROT_BSW6: ring[15:0] = {v[15:12], v[5:0], v[11:6]};
                ROT_RAL:  ring = {ring[15:0], ring[16]};
                ROT_RTL:  ring = {ring[14:0], ring[16:15]};
                ROT_RAR:  ring = {ring[0], ring[16:1]};
                ROT_RTR:  ring = {ring[1:0], ring[16:2]};
                ROT_BSW8: ring[15:0] = {v[7:0], v[15:8]};
                default: ;
            endcase
            {link_reg, v} = ring;
        end else if (!ins[9]) begin
            hit = (f[6] && v[15]) || (f[5] && v == '0) || (f[4] && link_reg);
            if (f[0]) r.skip = 1'b0;
            else if (!f[3]) r.skip = hit;
            else r.skip = !hit;
            if (f[7]) v = '0;
            if (f[2]) v = v | switch_word;
            r.halt = f[1];
        end else begin
            case (f[7:4])
                ROP_MOV: v = sv;
                ROP_SWP: begin
                    acc_file[sa] = v;
                    v = sv;
                end
                ROP_OR:  v = v | sv;
                ROP_XOR: v = v ^ sv;
                ROP_SHL, ROP_SLI: begin
                    cnt  = (f[7:4] == ROP_SLI) ? int'(ins[3:0]) + 1 : int'(sv[3:0]);
                    wide = {16'b0, v} << cnt;
                    link_reg = wide[16];
                    v = wide[15:0];
                end
                ROP_SHR, ROP_SRI, ROP_ASR, ROP_ASI: begin
                    cnt  = (f[7:4] == ROP_SRI || f[7:4] == ROP_ASI) ?
                           int'(ins[3:0]) + 1 : int'(sv[3:0]);
                    wide = (f[7:4] == ROP_ASR || f[7:4] == ROP_ASI) ?
                           {{16{v[15]}}, v} : {16'b0, v};
                    if (cnt != 0) begin
                        link_reg = wide[cnt-1];
                        wide = wide >> cnt;
                        v = wide[15:0];
                    end
                end
                default: ;
            endcase
        end
        acc_file[da] = v;
        r.dest = v;
        r.link = link_reg;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ACC_COUNT; i++) acc_file[i] = '0;
            link_reg    = 1'b0;
            switch_word = '0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_skip_next, m_halt_request, m_dest_value, m_link_value};
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: skip %0b halt %0b dest %04h link %0b",
                                 got.skip, got.halt, got.dest, got.link);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch: expected skip %0b halt %0b dest %04h",
                                      " link %0b, got skip %0b halt %0b dest %04h link %0b"},
                                     want.skip, want.halt, want.dest, want.link,
                                     got.skip, got.halt, got.dest, got.link);
                    end
                end
            end
            if (s_valid && s_ready) expected_q.push_back(execute_word(s_instruction));
            if (cfg_wr_en) switch_word = cfg_wr_data;
        end
        fail_count    <= mismatch_count;
        pending_count <= expected_q.size();
    end

endmodule

// ----- verif/tb_operate_instruction_unit.sv -----
// Testbench top for the operate instruction unit: clock, reset, stimulus, backpressure, verdict.
module tb_operate_instruction_unit;
    import oiu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 425;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [DATA_W-1:0]  cfg_wr_data   = '0;
    logic               s_valid       = 1'b0;
    logic [INSTR_W-1:0] s_instruction = '0;
    logic               m_ready       = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic               m_skip_next;
    logic               m_halt_request;
    logic [DATA_W-1:0]  m_dest_value;
    logic               m_link_value;
    int                 fail_count;
    int                 pending_count;
    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;
    int                 words_sent     = 0;
    int                 cycle_count    = 0;

    operate_instruction_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_instruction  (s_instruction),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_skip_next    (m_skip_next),
        .m_halt_request (m_halt_request),
        .m_dest_value   (m_dest_value),
        .m_link_value   (m_link_value)
    );

    oiu_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_instruction  (s_instruction),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_skip_next    (m_skip_next),
        .m_halt_request (m_halt_request),
        .m_dest_value   (m_dest_value),
        .m_link_value   (m_link_value),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [INSTR_W-1:0] g1(input logic [2:0] a, input logic [7:0] f);
        return {3'b000, a, 2'b00, f};
    endfunction

    function automatic logic [INSTR_W-1:0] g2(input logic [2:0] a, input logic [7:0] f);
        return {3'b000, a, 2'b01, f};
    endfunction

    function automatic logic [INSTR_W-1:0] rop(input logic [2:0] d, input logic [3:0] op,
                                               input logic [3:0] low);
        return {3'b000, d, 2'b11, op, low};
    endfunction

    function automatic logic [INSTR_W-1:0] random_word();
        logic [INSTR_W-1:0] w;
        int                 pick;
        w    = INSTR_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 38) begin
            w[8] = 1'b0;
        end else if (pick < 62) begin
            w[9:8] = 2'b01;
            w[0]   = ($urandom_range(7) == 0);
        end else if (pick < 92) begin
            w[9:8] = 2'b11;
            if ($urandom_range(3) != 0) w[7:4] = 4'($urandom_range(9));
        end
        return w;
    endfunction

    task automatic send_word(input logic [INSTR_W-1:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_instruction <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_switch(input logic [DATA_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_switch(16'h5A3C);
        send_word(g1(3'd0, 8'hA0));
        send_word(g1(3'd0, 8'h01));
        send_word(g2(3'd2, 8'h84));
        send_word(g1(3'd2, {4'h0, ROT_RAL, 1'b0}));
        send_word(g1(3'd2, {4'h0, ROT_RTL, 1'b0}));
        send_word(g1(3'd2, {4'h0, ROT_RAR, 1'b0}));
        send_word(g1(3'd2, {4'h0, ROT_RTR, 1'b0}));
        send_word(g1(3'd2, {4'h0, ROT_BSW6, 1'b0}));
        send_word(g1(3'd2, {4'h0, ROT_BSW8, 1'b0}));
        send_word(g1(3'd2, {4'h0, ROT_NONE2, 1'b0}));
        send_word(16'hE200 | g1(3'd3, 8'h25));
        send_word(g2(3'd2, 8'h70));
        send_word(g2(3'd2, 8'h78));
        send_word(g2(3'd0, 8'h08));
        send_word(g2(3'd1, 8'hF7));
        send_word(g2(3'd1, 8'h02));
        send_word(g2(3'd7, 8'h84));
        send_word(g1(3'd4, 8'hA0));
        for (int k = 0; k <= 10; k++) send_word(rop(3'd4, 4'(k), 4'hF));
        send_word(rop(3'd4, ROP_SLI, 4'hF));
        send_word(rop(3'd4, ROP_SHR, 4'h0));
        send_word(16'hFFFF);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_switch(16'h0000);
                1: write_switch(16'hFFFF);
                2: write_switch(DATA_W'($urandom));
                default: write_switch(16'h8001);
            endcase
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 52;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 52;
                end
                default: begin
                    src_idle_pct   = 11;
                    sink_stall_pct = 11;
                end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word());
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("covered %0d instruction words: group 1, group 2 and register ops",
                 words_sent);
        $display("four backpressure phases, switch word set five times incl. 0000 and FFFF");
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- operate_instruction_unit.f -----
hw/rtl/oiu_pkg.sv
hw/rtl/oiu_state.sv
hw/rtl/oiu_exec.sv
hw/rtl/operate_instruction_unit.sv
verif/oiu_result_checker.sv
verif/tb_operate_instruction_unit.sv
